FILE: rtl/cfs_pkg.sv
// Shared types and constants for the CSV field offset scanner.
`default_nettype none

package cfs_pkg;

    localparam logic [2:0] KIND_FIELD    = 3'd0;
    localparam logic [2:0] KIND_END      = 3'd1;
    localparam logic [2:0] KIND_TOO_MANY = 3'd2;
    localparam logic [2:0] KIND_TOO_FEW  = 3'd3;
    localparam logic [2:0] KIND_TOO_LONG = 3'd4;

    localparam logic [15:0] MAX_ROW_BYTES = 16'd65534;
    localparam logic [7:0]  CHAR_COMMA    = 8'h2C;
    localparam logic [7:0]  CHAR_QUOTE    = 8'h22;
    localparam logic [3:0]  CHUNK_BYTES   = 4'd8;

    // One classified input beat as it waits in the queue.
    typedef struct packed {
        logic [7:0] quote_mask;
        logic [7:0] comma_mask;
        logic [3:0] count;
        logic       row_end;
    } class_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] offset;
        logic [6:0]  field_index;
        logic        last_of_run;
    } result_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic   valid;
        class_t entry;
    } head_t;

endpackage

`default_nettype wire

FILE: rtl/cfs_ifs.sv
// Channel interfaces of the CSV field offset scanner.
`default_nettype none

interface cfs_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] chunk_bytes;
    logic [3:0]  valid_bytes;
    logic        row_end;
    modport source (output valid, output chunk_bytes, output valid_bytes, output row_end,
                    input ready);
    modport sink (input valid, input chunk_bytes, input valid_bytes, input row_end,
                  output ready);
endinterface

interface cfs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] offset;
    logic [6:0]  field_index;
    logic        last_of_run;
    modport source (output valid, output kind, output offset, output field_index,
                    output last_of_run, input ready);
    modport sink (input valid, input kind, input offset, input field_index,
                  input last_of_run, output ready);
endinterface

interface cfs_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/csv_field_offset_scanner.sv
// CSV field offset scanner top level: configuration register, front end and back end.
//
// Channels: "item" carries eight row bytes per beat with a valid byte count and an
// end-of-row mark. "result" carries one result per beat: a field start offset, the row
// end offset, or an error code, with last_of_run set on the final result of an item.
// "cfg" writes the expected field count; it is always ready. It is to be written only
// while idle; the user is bound to this, as the block does not enforce it. The front
// end classifies each beat and places it in a two-entry queue, so it keeps taking
// beats while the back end works. The back end takes a beat from the queue registers
// and handles one byte per cycle while the result channel is not stalled, stepping
// through its byte, end and flush phases for a beat before it takes the next. Each
// result waits in a pending slot until the next result of the same beat or the end of
// the beat moves it to the output register; the flush phase moves the last one. Reset
// clears the queue, the row state and the output valid flag, and sets the expected
// field count to one. When the receiver stalls, the back end stops and the queue
// fills, after which item ready drops; nothing is lost.
`default_nettype none

module csv_field_offset_scanner #(
    parameter int MAX_FIELDS = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cfs_in_if.sink      item,
    cfs_out_if.source   result,
    cfs_cfg_if.sink     cfg
);
    import cfs_pkg::*;

    logic [6:0] expected_reg;
    head_t      head;
    logic       pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= 7'd1;
        end
        else if (cfg.valid)
        begin
            expected_reg <= cfg.data;
        end
    end

    cfs_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .pop   (pop),
        .head  (head)
    );

    cfs_back #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .expected_fields (expected_reg),
        .pop             (pop),
        .result          (result)
    );

endmodule

`default_nettype wire

FILE: rtl/cfs_front.sv
// Front end: classifies input bytes and holds them in a two-entry queue.
`default_nettype none

module cfs_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    cfs_in_if.sink               item,
    input  wire logic            pop,
    output cfs_pkg::head_t       head
);
    import cfs_pkg::*;

    class_t     queue_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    class_t     classified;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            classified.quote_mask[i] = (item.chunk_bytes[8*i +: 8] == CHAR_QUOTE);
            classified.comma_mask[i] = (item.chunk_bytes[8*i +: 8] == CHAR_COMMA);
        end
        classified.count   = (item.valid_bytes > CHUNK_BYTES) ? CHUNK_BYTES : item.valid_bytes;
        classified.row_end = item.row_end;
    end

    assign item.ready  = (fill_reg != 2'd2);
    assign push        = item.valid && item.ready;
    assign head.valid  = (fill_reg != 2'd0);
    assign head.entry  = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cfs_back.sv
// Back end: walks queued bytes one per cycle unless output stalls; yields the results.
`default_nettype none

module cfs_back #(
    parameter int MAX_FIELDS = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cfs_pkg::head_t  head,
    input  wire logic [6:0]      expected_fields,
    output logic                 pop,
    cfs_out_if.source            result
);
    import cfs_pkg::*;

    localparam logic [1:0] PH_BYTES = 2'd0;
    localparam logic [1:0] PH_END   = 2'd1;
    localparam logic [1:0] PH_FLUSH = 2'd2;

    localparam logic [8:0] MAX_FIELDS_W = 9'(MAX_FIELDS);

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic        inq_reg, inq_next;
    logic [6:0]  fields_reg, fields_next;
    logic [15:0] pos_reg, pos_next;
    logic        failed_reg, failed_next;
    logic        pend_valid_reg, pend_valid_next;
    result_t     pend_reg, pend_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    logic        adv;
    logic        r_valid;
    result_t     r;
    logic [6:0]  want;

    always_comb
    begin
        if (expected_fields == 7'd0)
        begin
            want = 7'd1;
        end
        else if ({2'b00, expected_fields} > MAX_FIELDS_W)
        begin
            want = MAX_FIELDS_W[6:0];
        end
        else
        begin
            want = expected_fields;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        inq_next        = inq_reg;
        fields_next     = fields_reg;
        pos_next        = pos_reg;
        failed_next     = failed_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pop             = 1'b0;
        r_valid         = 1'b0;
        r               = '0;

        // The pending slot holds the newest result until we know whether it closes the beat.
        adv = !out_valid_reg || result.ready;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (adv && head.valid)
        begin
            case (phase_reg)
                PH_BYTES:
                begin
                    if (failed_reg || (idx_reg >= head.entry.count))
                    begin
                        phase_next = PH_END;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                        if (pos_reg >= MAX_ROW_BYTES)
                        begin
                            r_valid     = 1'b1;
                            r.kind      = KIND_TOO_LONG;
                            r.field_index = fields_reg;
                            failed_next = 1'b1;
                        end
                        else if (head.entry.quote_mask[idx_reg[2:0]])
                        begin
                            inq_next = !inq_reg;
                            pos_next = pos_reg + 16'd1;
                        end
                        else if (head.entry.comma_mask[idx_reg[2:0]] && !inq_reg)
                        begin
                            r_valid       = 1'b1;
                            r.field_index = fields_reg;
                            if (fields_reg >= want)
                            begin
                                r.kind      = KIND_TOO_MANY;
                                failed_next = 1'b1;
                            end
                            else
                            begin
                                r.kind      = KIND_FIELD;
                                r.offset    = pos_reg + 16'd1;
                                fields_next = fields_reg + 7'd1;
                                pos_next    = pos_reg + 16'd1;
                            end
                        end
                        else
                        begin
                            pos_next = pos_reg + 16'd1;
                        end
                    end
                end
                PH_END:
                begin
                    phase_next = PH_FLUSH;
                    if (head.entry.row_end)
                    begin
                        if (!failed_reg)
                        begin
                            r_valid       = 1'b1;
                            r.field_index = fields_reg;
                            if (fields_reg != want)
                            begin
                                r.kind = KIND_TOO_FEW;
                            end
                            else
                            begin
                                r.kind   = KIND_END;
                                r.offset = pos_reg + 16'd1;
                            end
                        end
                        inq_next    = 1'b0;
                        fields_next = 7'd1;
                        pos_next    = 16'd0;
                        failed_next = 1'b0;
                    end
                end
                PH_FLUSH:
                begin
                    if (pend_valid_reg)
                    begin
                        out_next             = pend_reg;
                        out_next.last_of_run = 1'b1;
                        out_valid_next       = 1'b1;
                        pend_valid_next      = 1'b0;
                    end
                    pop        = 1'b1;
                    idx_next   = 4'd0;
                    phase_next = PH_BYTES;
                end
                default:
                begin
                    phase_next = PH_BYTES;
                end
            endcase

            if (r_valid)
            begin
                if (pend_valid_reg)
                begin
                    out_next             = pend_reg;
                    out_next.last_of_run = 1'b0;
                    out_valid_next       = 1'b1;
                end
                pend_next       = r;
                pend_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_BYTES;
            idx_reg        <= 4'd0;
            inq_reg        <= 1'b0;
            fields_reg     <= 7'd1;
            pos_reg        <= 16'd0;
            failed_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            inq_reg        <= inq_next;
            fields_reg     <= fields_next;
            pos_reg        <= pos_next;
            failed_reg     <= failed_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = out_reg.kind;
    assign result.offset      = out_reg.offset;
    assign result.field_index = out_reg.field_index;
    assign result.last_of_run = out_reg.last_of_run;

endmodule

`default_nettype wire
